// ===== rtl/tlvp_pkg.sv =====
`timescale 1ns / 1ps
package tlvp_pkg;

  // fixed field widths
  localparam int BUF_LEN_W           = 16;
  localparam int DEFAULT_OFFSET_BITS = 16;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // first octets that announce a 2 or 4 byte extension (anything above means 8)
  localparam logic [7:0] VN_EXT_TWO  = 8'd253;
  localparam logic [7:0] VN_EXT_FOUR = 8'd254;

  // element kinds on the result channel
  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_INT = 1'b1;

  typedef enum logic [1:0] {
    MODE_HDR     = 2'd0,
    MODE_INT     = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_PAST   = 3'd1,
    ST_TYPE   = 3'd2,
    ST_LEN    = 3'd3,
    ST_BADLEN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TYPE_EXT  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_EXT   = 3'd3,
    PH_INT       = 3'd4
  } phase_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic        restart;
    logic        is_int;
    logic [7:0]  data_byte;
    logic [31:0] expected_type;
    logic [3:0]  int_length;
  } item_t;

endpackage

// ===== rtl/tlvp_if.sv =====
`timescale 1ns / 1ps
interface tlvp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [1:0]  mode;
  logic [31:0] expected_type;
  logic [3:0]  int_length;

  modport source (output valid, data_byte, mode, expected_type, int_length, input ready);
  modport sink   (input valid, data_byte, mode, expected_type, int_length, output ready);
endinterface

interface tlvp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value;
  logic        element_kind;

  modport source (output valid, status, value, element_kind, input ready);
  modport sink   (input valid, status, value, element_kind, output ready);
endinterface

interface tlvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] buffer_length;

  modport source (output valid, buffer_length, input ready);
  modport sink   (input valid, buffer_length, output ready);
endinterface

// ===== rtl/tlvp_front.sv =====
`timescale 1ns / 1ps
module tlvp_front
  import tlvp_pkg::*;
(
  tlvp_in_if.sink in_chan,
  input  logic    q_full,
  output logic    push,
  output item_t   push_item
);

  logic accept;

  // take a request whenever the queue has room
  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  // unused mode has no effect, so it never enters the queue
  assign push = accept && (mode_t'(in_chan.mode) != MODE_UNUSED);

  // classify the request for the back end
  always_comb begin
    push_item.restart       = (mode_t'(in_chan.mode) == MODE_RESTART);
    push_item.is_int        = (mode_t'(in_chan.mode) == MODE_INT);
    push_item.data_byte     = in_chan.data_byte;
    push_item.expected_type = in_chan.expected_type;
    push_item.int_length    = in_chan.int_length;
  end

endmodule

// ===== rtl/tlvp_queue.sv =====
`timescale 1ns / 1ps
module tlvp_queue
  import tlvp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  q_valid,
  output item_t q_item,
  input  logic  pop
);

  item_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/tlvp_back.sv =====
`timescale 1ns / 1ps
module tlvp_back
  import tlvp_pkg::*;
#(
  parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 pop,
  input  logic                 cfg_valid,
  input  logic [BUF_LEN_W-1:0] cfg_buffer_length,
  tlvp_out_if.source           out_chan
);

  // compare width: wide enough for either the offset or the buffer length, plus a carry
  localparam int CW = ((OFFSET_BITS > BUF_LEN_W) ? OFFSET_BITS : BUF_LEN_W) + 1;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             pend_r, pend_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [31:0]            held_r, held_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [BUF_LEN_W-1:0]   buflen_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [63:0]            out_value_r;
  logic                   out_kind_r;

  logic                   step;
  logic [7:0]             b;
  logic [OFFSET_BITS-1:0] off_inc;
  logic [CW-1:0]          off_ext, off_inc_ext, buf_ext, len_diff;
  logic                   room1, room_hdr, room_int, int_ok, short_vn;
  logic [3:0]             hdr_n, pend_dec;
  logic [63:0]            acc_shift, fin_acc;
  logic [31:0]            type_cmp;
  logic                   type_bad, len_bad;

  logic                   emit;
  status_t                emit_status;
  logic [63:0]            emit_value;
  logic                   emit_kind;

  // a request is processed when the result register can take what it may produce
  assign pop  = q_valid && (!out_valid_r || out_chan.ready);
  assign step = pop && !q_item.restart;
  assign b    = q_item.data_byte;

  // bound checks against the configured buffer length, exact and unwrapped
  assign off_inc     = off_r + 1'b1;
  assign off_ext     = CW'(off_r);
  assign off_inc_ext = CW'(off_inc);
  assign buf_ext     = CW'(buflen_r);
  assign hdr_n       = (b == VN_EXT_TWO) ? 4'd2 : (b == VN_EXT_FOUR) ? 4'd4 : 4'd8;
  assign short_vn    = (b < VN_EXT_TWO);
  assign int_ok      = q_item.int_length inside {4'd1, 4'd2, 4'd4, 4'd8};
  assign room1       = (off_ext + CW'(1)) <= buf_ext;
  assign room_hdr    = (off_inc_ext + CW'(hdr_n)) <= buf_ext;
  assign room_int    = (off_ext + CW'(q_item.int_length)) <= buf_ext;

  // value of a finishing variable number and its checks
  assign acc_shift = {acc_r[55:0], b};
  assign fin_acc   = (phase_r == PH_IDLE || phase_r == PH_LEN_FIRST) ? {56'd0, b} : acc_shift;
  assign type_cmp  = (phase_r == PH_IDLE) ? q_item.expected_type : held_r;
  assign type_bad  = (fin_acc != {32'd0, type_cmp});
  assign len_diff  = buf_ext - off_inc_ext;
  assign len_bad   = (off_inc_ext > buf_ext) || (fin_acc > 64'(len_diff));
  assign pend_dec  = pend_r - 1'b1;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    off_nxt   = off_r;
    if (pop && q_item.restart) begin
      phase_nxt = PH_IDLE;
      pend_nxt  = '0;
      acc_nxt   = '0;
      off_nxt   = '0;
    end else if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (!q_item.is_int) begin
            held_nxt = q_item.expected_type;
            if (room1) begin
              off_nxt = off_inc;
              acc_nxt = {56'd0, b};
              if (short_vn) begin
                phase_nxt = type_bad ? PH_IDLE : PH_LEN_FIRST;
                pend_nxt  = '0;
              end else if (room_hdr) begin
                acc_nxt   = '0;
                pend_nxt  = hdr_n;
                phase_nxt = PH_TYPE_EXT;
              end
            end
          end else if (int_ok && room_int) begin
            off_nxt   = off_inc;
            acc_nxt   = {56'd0, b};
            pend_nxt  = q_item.int_length - 1'b1;
            phase_nxt = (q_item.int_length == 4'd1) ? PH_IDLE : PH_INT;
          end
        end
        PH_TYPE_EXT: begin
          off_nxt  = off_inc;
          acc_nxt  = acc_shift;
          pend_nxt = pend_dec;
          if (pend_dec == '0) begin
            phase_nxt = type_bad ? PH_IDLE : PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (!room1) begin
            phase_nxt = PH_IDLE;
            pend_nxt  = '0;
          end else begin
            off_nxt = off_inc;
            acc_nxt = {56'd0, b};
            if (short_vn || !room_hdr) begin
              phase_nxt = PH_IDLE;
              pend_nxt  = '0;
            end else begin
              acc_nxt   = '0;
              pend_nxt  = hdr_n;
              phase_nxt = PH_LEN_EXT;
            end
          end
        end
        PH_LEN_EXT, PH_INT: begin
          off_nxt  = off_inc;
          acc_nxt  = acc_shift;
          pend_nxt = pend_dec;
          if (pend_dec == '0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          pend_nxt  = '0;
        end
      endcase
    end
  end

  // result outputs
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    emit_kind   = KIND_HDR;
    if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (!q_item.is_int) begin
            if (!room1) begin
              emit        = 1'b1;
              emit_status = ST_PAST;
            end else if (short_vn && type_bad) begin
              emit        = 1'b1;
              emit_status = ST_TYPE;
            end else if (!short_vn && !room_hdr) begin
              emit        = 1'b1;
              emit_status = ST_PAST;
            end
          end else begin
            emit_kind = KIND_INT;
            if (!int_ok) begin
              emit        = 1'b1;
              emit_status = ST_BADLEN;
            end else if (!room_int) begin
              emit        = 1'b1;
              emit_status = ST_PAST;
            end else if (q_item.int_length == 4'd1) begin
              emit       = 1'b1;
              emit_value = {56'd0, b};
            end
          end
        end
        PH_TYPE_EXT: begin
          if (pend_dec == '0 && type_bad) begin
            emit        = 1'b1;
            emit_status = ST_TYPE;
          end
        end
        PH_LEN_FIRST: begin
          if (!room1) begin
            emit        = 1'b1;
            emit_status = ST_PAST;
          end else if (short_vn) begin
            emit = 1'b1;
            if (len_bad) begin
              emit_status = ST_LEN;
            end else begin
              emit_value = fin_acc;
            end
          end else if (!room_hdr) begin
            emit        = 1'b1;
            emit_status = ST_PAST;
          end
        end
        PH_LEN_EXT: begin
          if (pend_dec == '0) begin
            emit = 1'b1;
            if (len_bad) begin
              emit_status = ST_LEN;
            end else begin
              emit_value = fin_acc;
            end
          end
        end
        PH_INT: begin
          emit_kind = KIND_INT;
          if (pend_dec == '0) begin
            emit       = 1'b1;
            emit_value = acc_shift;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pend_r   <= '0;
      acc_r    <= '0;
      held_r   <= '0;
      off_r    <= '0;
      buflen_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      off_r   <= off_nxt;
      if (cfg_valid) begin
        buflen_r <= cfg_buffer_length;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_status_r <= emit_status;
      out_value_r  <= emit_value;
      out_kind_r   <= emit_kind;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.value        = out_value_r;
  assign out_chan.element_kind = out_kind_r;

endmodule

// ===== rtl/tlv_header_and_integer_parser.sv =====
`timescale 1ns / 1ps
// Byte-serial TLV decoder: takes one buffer byte per clock while the request queue has room
// and reports each type-length header or non-negative integer as a single result (status,
// value, kind). Throughput is one request per cycle while the queue is not full; the back
// end decodes a byte as it pops the request from the queue. A request's result, if any,
// shows on out_chan once the request is written into the four-entry request queue at the
// accepting edge and is decoded into the result register when the back end pops it. in_chan
// stays ready until that queue is full, so a stalled result side holds up input only after
// four further requests. buffer_length is written through cfg_chan, which is always ready.
module tlv_header_and_integer_parser
  import tlvp_pkg::*;
#(
  parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  tlvp_in_if.sink     in_chan,
  tlvp_out_if.source  out_chan,
  tlvp_cfg_if.sink    cfg_chan
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  assign cfg_chan.ready = 1'b1;

  // front: accept and classify requests
  tlvp_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // request queue
  tlvp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // back: decoder and result register
  tlvp_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .cfg_valid         (cfg_chan.valid),
    .cfg_buffer_length (cfg_chan.buffer_length),
    .out_chan          (out_chan)
  );

endmodule

// ===== test/tb_tlv_header_and_integer_parser.sv =====
`timescale 1ns / 1ps
module tb_tlv_header_and_integer_parser;
  import tlvp_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 10;
  localparam int HOLD_CYCLES   = 60;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    logic [7:0]  data_byte;
    mode_t       mode;
    logic [31:0] expected_type;
    logic [3:0]  int_length;
  } tlv_req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
    logic        element_kind;
  } tlv_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tlvp_in_if  in_chan ();
  tlvp_out_if out_chan ();
  tlvp_cfg_if cfg_chan ();

  tlv_header_and_integer_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #1 clk = ~clk;

  // decoder state as predicted from accepted requests
  phase_t                         ph        = PH_IDLE;
  logic [3:0]                     pend      = '0;
  logic [63:0]                    acc       = '0;
  logic [31:0]                    held_type = '0;
  logic [DEFAULT_OFFSET_BITS-1:0] offs      = '0;
  logic [BUF_LEN_W-1:0]           buf_len   = '0;

  tlv_result_t due_results[$];

  int  fail_count    = 0;
  int  requests_sent = 0;
  int  results_seen  = 0;
  int  hdr_results   = 0;
  int  int_results   = 0;
  int  err_results   = 0;
  int  cfg_writes    = 0;
  bit  no_gaps       = 1'b0;
  bit  hold_req      = 1'b0;

  function automatic bit has_room(input logic [63:0] n);
    return (64'(offs) + n) <= 64'(buf_len);
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    acc  = {acc[55:0], b};
    offs = offs + 1'b1;
  endfunction

  function automatic void report_element(input status_t st, input logic [63:0] v,
                                         input logic kind);
    due_results.push_back('{status: st, value: v, element_kind: kind});
    ph   = PH_IDLE;
    pend = '0;
  endfunction

  // first octet of a variable number, bound checks on octet then extension
  function automatic status_t varnum_first(input logic [7:0] b);
    logic [3:0] n;
    if (!has_room(64'd1)) return ST_PAST;
    acc = '0;
    take_byte(b);
    if (b < VN_EXT_TWO) begin
      pend = '0;
      return ST_OK;
    end
    n = (b == VN_EXT_TWO) ? 4'd2 : (b == VN_EXT_FOUR) ? 4'd4 : 4'd8;
    if (!has_room(64'(n))) return ST_PAST;
    acc  = '0;
    pend = n;
    return ST_OK;
  endfunction

  function automatic void finish_type();
    if (acc != {32'b0, held_type}) begin
      report_element(ST_TYPE, '0, KIND_HDR);
    end else begin
      ph   = PH_LEN_FIRST;
      pend = '0;
    end
  endfunction

  function automatic void finish_length();
    if (64'(offs) > 64'(buf_len) || acc > (64'(buf_len) - 64'(offs)))
      report_element(ST_LEN, '0, KIND_HDR);
    else
      report_element(ST_OK, acc, KIND_HDR);
  endfunction

  // advance the predicted decoder by one accepted request
  function automatic void decode_request(input tlv_req_t r);
    status_t    st;
    logic [3:0] n;
    if (r.mode == MODE_RESTART) begin
      ph   = PH_IDLE;
      pend = '0;
      acc  = '0;
      offs = '0;
      return;
    end
    if (r.mode == MODE_UNUSED) return;
    case (ph)
      PH_IDLE: begin
        if (r.mode == MODE_HDR) begin
          held_type = r.expected_type;
          st = varnum_first(r.data_byte);
          if (st != ST_OK) report_element(st, '0, KIND_HDR);
          else if (pend == 0) finish_type();
          else ph = PH_TYPE_EXT;
        end else begin
          n = r.int_length;
          if (!(n inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
            report_element(ST_BADLEN, '0, KIND_INT);
          end else if (!has_room(64'(n))) begin
            report_element(ST_PAST, '0, KIND_INT);
          end else begin
            acc = '0;
            take_byte(r.data_byte);
            pend = n - 1'b1;
            if (pend == 0) report_element(ST_OK, acc, KIND_INT);
            else ph = PH_INT;
          end
        end
      end
      PH_TYPE_EXT: begin
        take_byte(r.data_byte);
        pend = pend - 1'b1;
        if (pend == 0) finish_type();
      end
      PH_LEN_FIRST: begin
        st = varnum_first(r.data_byte);
        if (st != ST_OK) report_element(st, '0, KIND_HDR);
        else if (pend == 0) finish_length();
        else ph = PH_LEN_EXT;
      end
      PH_LEN_EXT: begin
        take_byte(r.data_byte);
        pend = pend - 1'b1;
        if (pend == 0) finish_length();
      end
      PH_INT: begin
        take_byte(r.data_byte);
        pend = pend - 1'b1;
        if (pend == 0) report_element(ST_OK, acc, KIND_INT);
      end
      default: begin
        ph   = PH_IDLE;
        pend = '0;
      end
    endcase
  endfunction

  // mostly short stalls, now and then a long one
  function automatic int stall_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // offer one request and hold it until it is taken
  task automatic send_request(input logic [7:0] b, input mode_t m,
                              input logic [31:0] et, input logic [3:0] il);
    tlv_req_t r;
    int       gap;
    r = '{data_byte: b, mode: m, expected_type: et, int_length: il};
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.mode          <= m;
    in_chan.expected_type <= et;
    in_chan.int_length    <= il;
    do @(posedge clk); while (!in_chan.ready);
    decode_request(r);
    requests_sent++;
    gap = (no_gaps || $urandom_range(0, 99) < 60) ? 0 : stall_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_restart();
    send_request(8'($urandom), MODE_RESTART, $urandom, 4'($urandom_range(0, 15)));
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_length(input logic [15:0] len);
    wait_idle();
    cfg_chan.valid         <= 1'b1;
    cfg_chan.buffer_length <= len;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    buf_len = len;
    cfg_writes++;
  endtask

  function automatic void add_varnum(ref logic [7:0] q[$], input int cls,
                                     input logic [63:0] v);
    int nb;
    case (cls)
      0: begin
        q.push_back(v[7:0]);
        nb = 0;
      end
      1: begin
        q.push_back(VN_EXT_TWO);
        nb = 2;
      end
      2: begin
        q.push_back(VN_EXT_FOUR);
        nb = 4;
      end
      default: begin
        q.push_back(8'hFF);
        nb = 8;
      end
    endcase
    for (int i = nb - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] pick_varnum_value(input int cls, input bit mostly_small);
    bit wide;
    wide = !mostly_small || ($urandom_range(0, 3) == 0);
    case (cls)
      0:       return wide ? 64'($urandom_range(0, 252)) : 64'($urandom_range(0, 20));
      1:       return wide ? 64'($urandom_range(0, 65535)) : 64'($urandom_range(0, 40));
      2:       return wide ? 64'($urandom) : 64'($urandom_range(0, 40));
      default: return wide ? {$urandom, $urandom} : 64'($urandom_range(0, 40));
    endcase
  endfunction

  // a type-length header with random encodings, mostly of the wanted type
  task automatic send_header();
    logic [7:0]  seq[$];
    logic [63:0] tval;
    logic [63:0] lval;
    logic [31:0] et;
    int          tc;
    int          lc;
    tc   = $urandom_range(0, 3);
    tval = pick_varnum_value(tc, 1'b0);
    if (tc == 3 && $urandom_range(0, 9) != 0) tval[63:32] = '0;
    et = ($urandom_range(0, 9) == 0) ? $urandom : tval[31:0];
    lc   = $urandom_range(0, 3);
    lval = pick_varnum_value(lc, 1'b1);
    add_varnum(seq, tc, tval);
    add_varnum(seq, lc, lval);
    foreach (seq[i]) begin
      if (i == 0)
        send_request(seq[i], MODE_HDR, et, 4'($urandom_range(0, 15)));
      else
        send_request(seq[i], ($urandom_range(0, 9) == 0) ? MODE_INT : MODE_HDR,
                     $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  // a big-endian integer, now and then with a bad byte count
  task automatic send_integer();
    logic [3:0] n;
    case ($urandom_range(0, 4))
      0:       n = 4'd1;
      1:       n = 4'd2;
      2:       n = 4'd4;
      3:       n = 4'd8;
      default: n = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
    endcase
    send_request(8'($urandom), MODE_INT, $urandom, n);
    if (n inside {4'd2, 4'd4, 4'd8}) begin
      for (int i = 1; i < n; i++)
        send_request(8'($urandom), ($urandom_range(0, 4) == 0) ? MODE_HDR : MODE_INT,
                     $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  // after reset the buffer is empty, so every element with a valid byte count fails its bound check
  task automatic test_empty_buffer();
    send_request(8'd5, MODE_HDR, 32'd5, 4'd0);
    send_request(8'h00, MODE_INT, 32'd0, 4'd3);
    send_request(8'hFF, MODE_INT, 32'hFFFF_FFFF, 4'd1);
    send_request(8'hA5, MODE_UNUSED, 32'd0, 4'd15);
    send_restart();
    wait_idle();
  endtask

  task automatic test_well_formed();
    write_buffer_length(16'hFFFF);
    send_restart();
    // single byte integer at its maximum
    send_request(8'hFF, MODE_INT, 32'd0, 4'd1);
    // eight byte integer of all ones, continuation bytes flagged alternately as header and integer
    send_request(8'hFF, MODE_INT, 32'd0, 4'd8);
    for (int i = 1; i < 8; i++)
      send_request(8'hFF, (i % 2) ? MODE_HDR : MODE_INT, 32'hFFFF_FFFF, 4'd0);
    // two byte type, two byte length
    send_request(VN_EXT_TWO, MODE_HDR, 32'h0000_1234, 4'd0);
    send_request(8'h12, MODE_HDR, 32'd0, 4'd0);
    send_request(8'h34, MODE_HDR, 32'd0, 4'd0);
    send_request(VN_EXT_TWO, MODE_HDR, 32'd0, 4'd0);
    send_request(8'h00, MODE_HDR, 32'd0, 4'd0);
    send_request(8'h2A, MODE_HDR, 32'd0, 4'd0);
    // type mismatch
    send_request(8'h00, MODE_HDR, 32'h8000_0001, 4'd0);
    // length larger than what is left of the buffer
    send_request(8'd7, MODE_HDR, 32'd7, 4'd0);
    send_request(VN_EXT_TWO, MODE_HDR, 32'd0, 4'd0);
    send_request(8'hFF, MODE_HDR, 32'd0, 4'd0);
    send_request(8'hFF, MODE_HDR, 32'd0, 4'd0);
    wait_idle();
  endtask

  task automatic test_bounds();
    write_buffer_length(16'd3);
    send_restart();
    // first octet fits, its four byte extension does not
    send_request(VN_EXT_FOUR, MODE_HDR, 32'd0, 4'd0);
    // integer that would run past the end
    send_request(8'h11, MODE_INT, 32'd0, 4'd4);
    // offset beyond a buffer that shrank during a header
    write_buffer_length(16'hFFFF);
    send_restart();
    send_request(8'd5, MODE_HDR, 32'd5, 4'd0);
    send_request(VN_EXT_TWO, MODE_HDR, 32'd0, 4'd0);
    write_buffer_length(16'd2);
    send_request(8'h00, MODE_HDR, 32'd0, 4'd0);
    send_request(8'h01, MODE_HDR, 32'd0, 4'd0);
    wait_idle();
  endtask

  // result side holds off while integers keep coming, then full drain
  task automatic test_backpressure();
    write_buffer_length(16'hFFFF);
    send_restart();
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_request(8'($urandom), MODE_INT, $urandom, 4'd1);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic random_phase(input logic [15:0] len, input int count, input bit calm);
    int stop_at;
    int pick;
    write_buffer_length(len);
    no_gaps = calm;
    send_restart();
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (ph == PH_IDLE && 32'(offs) + 20 > 32'(buf_len) && $urandom_range(0, 1) == 0)
        send_restart();
      else if (pick < 50)
        send_header();
      else if (pick < 78)
        send_integer();
      else if (pick < 84)
        send_restart();
      else
        send_request(8'($urandom), mode_t'($urandom_range(0, 3)), $urandom,
                     4'($urandom_range(0, 15)));
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    random_phase(16'hFFFF, 180, 1'b0);
    random_phase(16'($urandom_range(8, 48)), 140, 1'b0);
    random_phase(16'd1, 50, 1'b0);
    random_phase(16'($urandom_range(0, 65535)), 170, 1'b1);
    random_phase(16'd0, 30, 1'b0);
    random_phase(16'd600, 150, 1'b0);
  endtask

  // result side: random stalls, or one long hold-off on request
  initial begin : result_sink
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
        out_chan.ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare every result taken with the oldest outstanding prediction
  always @(posedge clk) begin : check_results
    tlv_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (out_chan.element_kind == KIND_INT) int_results++;
      else hdr_results++;
      if (out_chan.status != ST_OK) err_results++;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d value %0h kind %0d",
               out_chan.status, out_chan.value, out_chan.element_kind);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.value !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, out_chan.value);
          fail_count++;
        end
        if (out_chan.element_kind !== want.element_kind) begin
          $error("element_kind: expected %0d, got %0d", want.element_kind,
                 out_chan.element_kind);
          fail_count++;
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.data_byte      <= '0;
    in_chan.mode           <= MODE_HDR;
    in_chan.expected_type  <= '0;
    in_chan.int_length     <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.buffer_length <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_buffer();
    test_well_formed();
    test_bounds();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    $display("run covered %0d requests and %0d buffer length writes", requests_sent,
             cfg_writes);
    $display("results checked: %0d (%0d headers, %0d integers, %0d with error status)",
             results_seen, hdr_results, int_results, err_results);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
